[rtl/utd_pkg.sv]
// Package for the UTF-8 to UCS-2 decoder: byte class constants, state widths
// and the structs passed between the decode logic and the result stage.
// No dependencies.
`default_nettype none

package utd_pkg;

    localparam int BYTE_W    = 8;
    localparam int UNIT_W    = 16;
    localparam int PARTIAL_W = 10;
    localparam int LEFT_W    = 2;
    localparam int SIX_W     = 6;

    localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7f;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_VALUE = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD3_VALUE = 8'he0;

    localparam logic [LEFT_W-1:0] LEFT_NONE = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE  = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_TWO  = 2'd2;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              bad_lead;
        logic              ends_string;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t result;
    } decode_out_t;

endpackage

`default_nettype wire

[rtl/utd_decode.sv]
// Byte decoder: holds the partial character state and classifies one byte.
// Depends on utd_pkg.
`default_nettype none

module utd_decode
    import utd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] byte_val,
    input  wire logic              last,
    output decode_out_t            dec
);

    logic [PARTIAL_W-1:0] partial_reg, partial_next;
    logic [LEFT_W-1:0]    left_reg, left_next;
    logic [SIX_W-1:0]     six;

    assign six = byte_val[SIX_W-1:0];

    always_comb
    begin
        partial_next = partial_reg;
        left_next    = left_reg;
        dec          = '0;
        if (left_reg != LEFT_NONE)
        begin
            if (left_reg == LEFT_ONE)
            begin
                dec.emit             = 1'b1;
                dec.result.code_unit = {partial_reg, six};
                partial_next         = '0;
                left_next            = LEFT_NONE;
            end
            else
            begin
                partial_next = {partial_reg[PARTIAL_W-SIX_W-1:0], six};
                left_next    = LEFT_ONE;
            end
        end
        else if (byte_val <= ASCII_MAX)
        begin
            dec.emit             = 1'b1;
            dec.result.code_unit = {{(UNIT_W-BYTE_W){1'b0}}, byte_val};
        end
        else if ((byte_val & LEAD2_MASK) == LEAD2_VALUE)
        begin
            partial_next = {{(PARTIAL_W-5){1'b0}}, byte_val[4:0]};
            left_next    = LEFT_ONE;
        end
        else if ((byte_val & LEAD3_MASK) == LEAD3_VALUE)
        begin
            partial_next = {{(PARTIAL_W-4){1'b0}}, byte_val[3:0]};
            left_next    = LEFT_TWO;
        end
        else
        begin
            dec.emit            = 1'b1;
            dec.result.bad_lead = 1'b1;
        end
        dec.result.ends_string = last;
        if (last)
        begin
            partial_next = '0;
            left_next    = LEFT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            left_reg    <= LEFT_NONE;
        end
        else if (advance)
        begin
            partial_reg <= partial_next;
            left_reg    <= left_next;
        end
    end

endmodule

`default_nettype wire

[rtl/utd_out_stage.sv]
// Result register: holds one decoded code unit until the consumer takes it.
// Depends on utd_pkg.
`default_nettype none

module utd_out_stage
    import utd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire decode_out_t dec,
    input  wire logic        out_stall,
    output logic             out_valid,
    output logic             free,
    output result_t          result
);

    logic    valid_reg;
    result_t result_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= dec.emit;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec.emit)
            result_reg <= dec.result;
    end

endmodule

`default_nettype wire

[rtl/utf8_to_ucs2_decoder.sv]
// UTF-8 to UCS-2 decoder top level: input register, byte decoder, result register.
// Path: a byte is held in the input register, then its code unit in the result
// register, where out_valid rises; out_stall can hold either register.
// Throughput: one byte per cycle; a byte advances whenever the result register
// is empty or being taken, so in_stall follows out_stall.
// Reset: rst_n clears the valid flags and the partial character state.
`default_nettype none

module utf8_to_ucs2_decoder
    import utd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic              end_of_string,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [UNIT_W-1:0]      code_unit,
    output logic                   bad_lead,
    output logic                   ends_string
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              free;
    logic              advance;
    logic              accept;
    decode_out_t       dec;
    result_t           result;

    assign advance  = in_valid_reg && free;
    assign in_stall = in_valid_reg && !free;
    assign accept   = in_valid && !in_stall;

    // hold the transaction until the decoder takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_in;
            last_reg <= end_of_string;
        end
    end

    utd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .byte_val (byte_reg),
        .last     (last_reg),
        .dec      (dec)
    );

    utd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .dec       (dec),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .free      (free),
        .result    (result)
    );

    assign code_unit   = result.code_unit;
    assign bad_lead    = result.bad_lead;
    assign ends_string = result.ends_string;

endmodule

`default_nettype wire

[rtl/utd_checker.sv]
// Port-level checks for the UTF-8 to UCS-2 decoder, bound to the top level.
// Depends on utd_pkg.
`default_nettype none

module utd_checker
    import utd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [UNIT_W-1:0] code_unit,
    input wire logic              bad_lead,
    input wire logic              ends_string
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_unit)
            && $stable(bad_lead) && $stable(ends_string))
        else $error("stalled result changed");

    // input never stalls while the result register is empty
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // bad lead byte always yields code unit zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_lead |-> code_unit == '0)
        else $error("bad lead with nonzero code unit");

    // no result is valid in the cycle after one in which reset is asserted, whatever the input
    a_idle_after_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid right after reset");

endmodule

bind utf8_to_ucs2_decoder utd_checker u_utd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_unit   (code_unit),
    .bad_lead    (bad_lead),
    .ends_string (ends_string)
);

`default_nettype wire
